>>> rtl/core/hevc_pkg.sv
// Shared types, constants and the arctangent table of the heading controller.
`default_nettype none
package hevc_pkg;

   localparam int CNT_W     = 5;
   localparam int TABLE_LEN = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IWR   = 2'd2;

   localparam logic [15:0] RST_GAIN  = 16'd5734;
   localparam logic [15:0] RST_LIMIT = 16'd4096;
   localparam logic [15:0] RST_IWR   = 16'd1024;

   localparam logic [31:0] INVK_Q16 = 32'd39797;
   localparam logic [31:0] INVK_Q30 = 32'd652032874;
   localparam logic [31:0] PI_Q29   = 32'd1686629713;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   typedef struct packed {
      logic start;
      logic vec_mode;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   function automatic logic [31:0] atan_at(input logic [CNT_W-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2F9;
         5'd15:   v = 32'h0000517C;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A2F;
         5'd19:   v = 32'h00000517;
         5'd20:   v = 32'h0000028B;
         5'd21:   v = 32'h00000145;
         5'd22:   v = 32'h000000A2;
         5'd23:   v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/hevc_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
`default_nettype none
module hevc_cordic #(
   parameter int CORDIC_STEPS = 16,
   parameter int CW = 34
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire hevc_pkg::cordic_ctl_type ctl,
   input  wire logic signed [CW-1:0]    x0,
   input  wire logic signed [CW-1:0]    y0,
   input  wire logic signed [CW-1:0]    z0,
   output logic signed [CW-1:0]         x,
   output logic signed [CW-1:0]         y,
   output logic signed [CW-1:0]         z,
   output hevc_pkg::cordic_stat_type    stat
);

   localparam int NSTEP = (CORDIC_STEPS < hevc_pkg::TABLE_LEN) ? CORDIC_STEPS :
                          hevc_pkg::TABLE_LEN;
   localparam logic [hevc_pkg::CNT_W-1:0] LAST = hevc_pkg::CNT_W'(NSTEP);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [hevc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in, mode_ff, mode_in;
   logic signed [CW-1:0] xs, ys, at;
   logic up;

   always_comb begin
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = signed'(CW'(hevc_pkg::atan_at(cnt_ff)));
      up = mode_ff ? (!y_ff[CW-1] && (|y_ff)) : z_ff[CW-1];
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      if (ctl.start) begin
         x_in = x0;
         y_in = y0;
         z_in = z0;
         cnt_in = '0;
         busy_in = 1'b1;
         mode_in = ctl.vec_mode;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            x_in = up ? x_ff + ys : x_ff - ys;
            y_in = up ? y_ff - xs : y_ff + xs;
            z_in = up ? z_ff + at : z_ff - at;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      cnt_ff <= cnt_in;
      mode_ff <= mode_in;
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff) else $error("CORDIC did not start.");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("CORDIC done without a run.");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= LAST) else $error("CORDIC step count overran.");

endmodule
`default_nettype wire

>>> rtl/core/heading_error_velocity_command_unit.sv
// Top level of the proportional heading controller: sequencer, multiplier and registers.
// Usage:
// The request channel (req_valid, req_stall, req_opcode, req_vel_x, req_vel_y) takes
// one word at a time. Opcode 0 stores the measured velocity and gives no response.
// Opcode 1 runs the command heading, the measured heading and the sin+cos
// through one shared CORDIC unit and the products through one shared registered
// multiplier, one product per cycle. A command word passes through the states
// VEC_CMD, MUL_MAG, VEC_MEAS, MUL_YAW1, MUL_YAW2, ROT, MUL_FWD, MUL_WHL and DONE
// before its response word is loaded into the output register. The sequencer
// returns to idle at the edge that loads the response word, so no new request
// is taken while a command is still in work.
// req_stall is high whenever a command is in work. The response word waits in an
// output register while rsp_stall is high; the next request is accepted meanwhile,
// and a finished command holds until the output register is free.
// The csr port writes heading_gain (index 0), heading_limit (1) and
// inverse_wheel_radius (2) at any edge with csr_write high; other indexes are ignored.
// Reset is synchronous: it restores the register defaults, clears the stored
// measurement to zero, empties the output register and returns the sequencer to idle.
`default_nettype none
module heading_error_velocity_command_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int VEL_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_opcode,
   input  wire logic signed [VEL_BITS-1:0]      req_vel_x,
   input  wire logic signed [VEL_BITS-1:0]      req_vel_y,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [15:0]                   rsp_forward_speed,
   output logic signed [15:0]                   rsp_yaw_rate,
   output logic signed [23:0]                   rsp_wheel_rate,
   output logic signed [15:0]                   rsp_heading_error_out,
   input  wire                                  csr_write,
   input  wire [hevc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [hevc_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int CW   = (VEL_BITS + 11 > 34) ? VEL_BITS + 11 : 34;
   localparam int MBW  = (VEL_BITS + 2 > 32) ? VEL_BITS + 2 : 32;
   localparam int PW   = CW + MBW;
   localparam int MAGW = VEL_BITS + 2;
   localparam int SCW  = 20;

   localparam logic signed [PW-1:0] S16_MAX = PW'(32767);
   localparam logic signed [PW-1:0] S16_MIN = ~S16_MAX;
   localparam logic signed [PW-1:0] S24_MAX = PW'(8388607);
   localparam logic signed [PW-1:0] S24_MIN = ~S24_MAX;
   localparam logic signed [CW-1:0] QTR_P = CW'(64'sd1073741824);
   localparam logic signed [CW-1:0] QTR_N = -QTR_P;
   localparam logic signed [CW-1:0] HALF = CW'(64'sd2147483648);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_VEC_CMD  = 11'b000_0000_0010,
      ST_MUL_MAG  = 11'b000_0000_0100,
      ST_VEC_MEAS = 11'b000_0000_1000,
      ST_MUL_YAW1 = 11'b000_0001_0000,
      ST_MUL_YAW2 = 11'b000_0010_0000,
      ST_ROT      = 11'b000_0100_0000,
      ST_MUL_FWD  = 11'b000_1000_0000,
      ST_MUL_WHL  = 11'b001_0000_0000,
      ST_DONE     = 11'b010_0000_0000,
      ST_SPARE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [14:0] gain_ff, gain_in, limit_ff, limit_in;
   logic [15:0] iwr_ff, iwr_in;
   logic signed [VEL_BITS-1:0] meas_x_ff, meas_x_in, meas_y_ff, meas_y_in;
   logic signed [VEL_BITS-1:0] cmd_x_ff, cmd_x_in, cmd_y_ff, cmd_y_in;
   logic zero_cmd_ff, zero_cmd_in, zero_meas_ff, zero_meas_in, neg_ff, neg_in;
   logic [15:0] a_cmd_ff, a_cmd_in;
   logic signed [MAGW-1:0] mag_ff, mag_in;
   logic signed [15:0] err_ff, err_in, yaw_ff, yaw_in, fwd_ff, fwd_in;
   logic signed [PW-1:0] mul_ff, mul_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_fwd_ff, out_fwd_in, out_yaw_ff, out_yaw_in, out_err_ff, out_err_in;
   logic signed [23:0] out_whl_ff, out_whl_in;

   hevc_pkg::cordic_ctl_type ctl;
   hevc_pkg::cordic_stat_type cst;
   logic signed [CW-1:0] c_x0, c_y0, c_z0, c_x, c_y, c_z;

   logic signed [CW-1:0] mul_a;
   logic signed [MBW-1:0] mul_b;
   logic signed [CW-1:0] vx, vy, zr;
   logic [VEL_BITS-1:0] vsel_x, vsel_y;
   logic [31:0] zsum;
   logic [15:0] a_now, diff;
   logic signed [16:0] e17, lim17;
   logic signed [CW:0] sum, sum_r;
   logic signed [SCW-1:0] sc;
   logic signed [PW-1:0] rnd16, rnd44, rnd8, rnd24;
   logic signed [15:0] fwd_sat, yaw_sat;
   logic signed [23:0] whl_sat;
   logic accept, rsp_free;

   hevc_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS),
      .CW(CW)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .x0(c_x0),
      .y0(c_y0),
      .z0(c_z0),
      .x(c_x),
      .y(c_y),
      .z(c_z),
      .stat(cst)
   );

   always_comb begin
      accept = req_valid && (state_ff == ST_IDLE);
      rsp_free = !rsp_valid_ff || !rsp_stall;

      // Vectoring operands: the vector scaled by 2^8, mirrored into the right half plane.
      vsel_x = (state_ff == ST_IDLE) ? req_vel_x : meas_x_ff;
      vsel_y = (state_ff == ST_IDLE) ? req_vel_y : meas_y_ff;
      vx = CW'(signed'(vsel_x)) <<< 8;
      vy = CW'(signed'(vsel_y)) <<< 8;

      zr = CW'(err_ff) <<< 16;
      neg_in = neg_ff;
      ctl.start = 1'b0;
      ctl.vec_mode = 1'b1;
      c_x0 = vx;
      c_y0 = vy;
      c_z0 = '0;
      if (state_ff == ST_MUL_YAW2) begin
         ctl.vec_mode = 1'b0;
         c_x0 = signed'(CW'(hevc_pkg::INVK_Q30));
         c_y0 = '0;
         c_z0 = zr;
         neg_in = 1'b0;
         if (zr > QTR_P) begin
            c_z0 = zr - HALF;
            neg_in = 1'b1;
         end else if (zr < QTR_N) begin
            c_z0 = zr + HALF;
            neg_in = 1'b1;
         end
      end else if (vx < 0) begin
         c_x0 = -vx;
         c_y0 = -vy;
         c_z0 = signed'(CW'(hevc_pkg::HALF_TURN));
      end
      ctl.start = (accept && req_opcode) || (state_ff == ST_MUL_MAG) ||
                  (state_ff == ST_MUL_YAW2);

      zsum = c_z[31:0] + 32'h0000_8000;
      a_now = zsum[31:16];
      diff = a_cmd_ff - (zero_meas_ff ? 16'd0 : a_now);
      e17 = 17'(signed'(diff));
      lim17 = signed'({2'b00, limit_ff});
      if (e17 > lim17) begin
         e17 = lim17;
      end
      if (e17 < -lim17) begin
         e17 = -lim17;
      end

      sum = (CW+1)'(c_x) + (CW+1)'(c_y);
      sum_r = neg_ff ? -sum : sum;
      sum_r = (sum_r + (CW+1)'(8192)) >>> 14;
      sc = sum_r[SCW-1:0];

      rnd16 = (mul_ff + PW'(32768)) >>> 16;
      rnd44 = (mul_ff + (PW'(1) <<< 43)) >>> 44;
      rnd8 = (mul_ff + PW'(128)) >>> 8;
      rnd24 = (mul_ff + PW'(8388608)) >>> 24;
      fwd_sat = (rnd16 > S16_MAX) ? 16'sh7FFF : (rnd16 < S16_MIN) ? -16'sh8000 : rnd16[15:0];
      yaw_sat = (rnd44 > S16_MAX) ? 16'sh7FFF : (rnd44 < S16_MIN) ? -16'sh8000 : rnd44[15:0];
      whl_sat = (rnd8 > S24_MAX) ? 24'sh7FFFFF : (rnd8 < S24_MIN) ? -24'sh800000 : rnd8[23:0];

      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_MAG: begin
            mul_a = c_x;
            mul_b = signed'(MBW'(hevc_pkg::INVK_Q16));
         end
         ST_MUL_YAW1: begin
            mul_a = CW'(err_ff);
            mul_b = signed'(MBW'(gain_ff));
         end
         ST_MUL_YAW2: begin
            mul_a = mul_ff[CW-1:0];
            mul_b = signed'(MBW'(hevc_pkg::PI_Q29));
         end
         ST_MUL_FWD: begin
            mul_a = CW'(sc);
            mul_b = MBW'(mag_ff);
         end
         ST_MUL_WHL: begin
            mul_a = CW'(fwd_sat);
            mul_b = signed'(MBW'(iwr_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = (state_ff == ST_IDLE || state_ff == ST_VEC_CMD || state_ff == ST_VEC_MEAS ||
                state_ff == ST_ROT || state_ff == ST_DONE || state_ff == ST_SPARE) ?
               mul_ff : PW'(mul_a) * PW'(mul_b);

      gain_in = gain_ff;
      limit_in = limit_ff;
      iwr_in = iwr_ff;
      if (csr_write) begin
         unique case (csr_index)
            hevc_pkg::CSR_GAIN:  gain_in = csr_wdata[14:0];
            hevc_pkg::CSR_LIMIT: limit_in = csr_wdata[14:0];
            hevc_pkg::CSR_IWR:   iwr_in = csr_wdata;
            default: begin
            end
         endcase
      end

      state_in = state_ff;
      meas_x_in = meas_x_ff;
      meas_y_in = meas_y_ff;
      cmd_x_in = cmd_x_ff;
      cmd_y_in = cmd_y_ff;
      zero_cmd_in = zero_cmd_ff;
      zero_meas_in = zero_meas_ff;
      a_cmd_in = a_cmd_ff;
      mag_in = mag_ff;
      err_in = err_ff;
      yaw_in = yaw_ff;
      fwd_in = fwd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_fwd_in = out_fwd_ff;
      out_yaw_in = out_yaw_ff;
      out_whl_in = out_whl_ff;
      out_err_in = out_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode) begin
                  cmd_x_in = req_vel_x;
                  cmd_y_in = req_vel_y;
                  zero_cmd_in = (req_vel_x == '0) && (req_vel_y == '0);
                  state_in = ST_VEC_CMD;
               end else begin
                  meas_x_in = req_vel_x;
                  meas_y_in = req_vel_y;
               end
            end
         end
         ST_VEC_CMD: begin
            if (cst.done) begin
               a_cmd_in = zero_cmd_ff ? 16'd0 : a_now;
               state_in = ST_MUL_MAG;
            end
         end
         ST_MUL_MAG: begin
            zero_meas_in = (meas_x_ff == '0) && (meas_y_ff == '0);
            state_in = ST_VEC_MEAS;
         end
         ST_VEC_MEAS: begin
            if (cst.done) begin
               mag_in = rnd24[MAGW-1:0];
               err_in = e17[15:0];
               state_in = ST_MUL_YAW1;
            end
         end
         ST_MUL_YAW1: state_in = ST_MUL_YAW2;
         ST_MUL_YAW2: state_in = ST_ROT;
         ST_ROT: begin
            if (cst.done) begin
               yaw_in = yaw_sat;
               state_in = ST_MUL_FWD;
            end
         end
         ST_MUL_FWD: state_in = ST_MUL_WHL;
         ST_MUL_WHL: begin
            fwd_in = fwd_sat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_fwd_in = fwd_ff;
               out_yaw_in = yaw_ff;
               out_whl_in = whl_sat;
               out_err_in = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff <= hevc_pkg::RST_GAIN[14:0];
         limit_ff <= hevc_pkg::RST_LIMIT[14:0];
         iwr_ff <= hevc_pkg::RST_IWR;
         meas_x_ff <= '0;
         meas_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gain_ff <= gain_in;
         limit_ff <= limit_in;
         iwr_ff <= iwr_in;
         meas_x_ff <= meas_x_in;
         meas_y_ff <= meas_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_x_ff <= cmd_x_in;
      cmd_y_ff <= cmd_y_in;
      zero_cmd_ff <= zero_cmd_in;
      zero_meas_ff <= zero_meas_in;
      neg_ff <= neg_in;
      a_cmd_ff <= a_cmd_in;
      mag_ff <= mag_in;
      err_ff <= err_in;
      yaw_ff <= yaw_in;
      fwd_ff <= fwd_in;
      mul_ff <= mul_in;
      out_fwd_ff <= out_fwd_in;
      out_yaw_ff <= out_yaw_in;
      out_whl_ff <= out_whl_in;
      out_err_ff <= out_err_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_forward_speed = out_fwd_ff;
   assign rsp_yaw_rate = out_yaw_ff;
   assign rsp_wheel_rate = out_whl_ff;
   assign rsp_heading_error_out = out_err_ff;

   a_cordic_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VEC_CMD || state_ff == ST_VEC_MEAS || state_ff == ST_ROT) |->
      (cst.busy || cst.done)) else $error("Sequencer waits on an idle CORDIC.");
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("Finished word was not moved to the output register.");
   a_start_idle_cordic: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !cst.busy) else $error("CORDIC restarted while busy.");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench of the heading controller: stimulus, predictor and scoreboard.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS      = 16;
   localparam int DRAIN      = 80;
   localparam int STALL_WAIT = 6000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic               opcode;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
   } command_word_type;

   typedef struct {
      logic signed [15:0] forward_speed;
      logic signed [15:0] yaw_rate;
      logic signed [23:0] wheel_rate;
      logic signed [15:0] err_angle;
   } drive_word_type;

   class heading_scoreboard;
      logic [14:0]        gain;
      logic [14:0]        limit;
      logic [15:0]        inv_radius;
      logic signed [15:0] meas_x;
      logic signed [15:0] meas_y;
      drive_word_type     pending_words[$];
      int                 errors;
      logic [31:0]        arctan[STEPS];

      function new();
         arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
         gain = 15'd5734;
         limit = 15'd4096;
         inv_radius = 16'd1024;
         meas_x = '0;
         meas_y = '0;
         errors = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [15:0] data);
         case (idx)
            hevc_pkg::CSR_GAIN:  gain = data[14:0];
            hevc_pkg::CSR_LIMIT: limit = data[14:0];
            hevc_pkg::CSR_IWR:   inv_radius = data;
            default: ;
         endcase
      endfunction

      function void vector_heading(longint vx, longint vy, output logic [15:0] ang,
                                   output longint mag);
         longint x, y, xs, ys;
         logic [31:0] z, rounded;
         ang = '0;
         mag = 0;
         if (vx == 0 && vy == 0) return;
         x = vx * 256;
         y = vy * 256;
         z = '0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = hevc_pkg::HALF_TURN;
         end
         for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys;
               y -= xs;
               z += arctan[i];
            end else begin
               x -= ys;
               y += xs;
               z -= arctan[i];
            end
         end
         rounded = z + 32'h8000;
         ang = rounded[31:16];
         mag = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
      endfunction

      function longint sin_plus_cos(longint e);
         longint z, x, y, xs, ys;
         bit flip;
         z = e * 65536;
         x = 652032874;
         y = 0;
         flip = 0;
         if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31;
            flip = 1;
         end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31;
            flip = 1;
         end
         for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys;
               y += xs;
               z -= longint'(arctan[i]);
            end else begin
               x += ys;
               y -= xs;
               z += longint'(arctan[i]);
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         return (x + y + 8192) >>> 14;
      endfunction

      function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (64'sd1 <<< (w - 1)) - 1;
         lo = -hi - 1;
         return v > hi ? hi : (v < lo ? lo : v);
      endfunction

      function void note_command(command_word_type w);
         logic [15:0] ang_cmd, ang_meas, diff;
         longint mag, mag_meas, e, lim, sc, fwd, yaw, wheel;
         drive_word_type d;
         if (!w.opcode) begin
            meas_x = w.vel_x;
            meas_y = w.vel_y;
            return;
         end
         vector_heading(w.vel_x, w.vel_y, ang_cmd, mag);
         vector_heading(meas_x, meas_y, ang_meas, mag_meas);
         diff = ang_cmd - ang_meas;
         e = longint'(signed'(diff));
         lim = longint'(limit);
         if (e > lim) e = lim;
         if (e < -lim) e = -lim;
         sc = sin_plus_cos(e);
         fwd = clamp((sc * mag + 32768) >>> 16, 16);
         yaw = clamp((longint'(gain) * e * 1686629713 + (64'sd1 <<< 43)) >>> 44, 16);
         wheel = clamp((fwd * longint'(inv_radius) + 128) >>> 8, 24);
         d.forward_speed = fwd[15:0];
         d.yaw_rate = yaw[15:0];
         d.wheel_rate = wheel[23:0];
         d.err_angle = e[15:0];
         pending_words.insert(pending_words.size(), d);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      task check_drive(drive_word_type got);
         drive_word_type want;
         if (pending_words.size() == 0) begin
            report("unexpected response word", 1, 0);
            return;
         end
         want = pending_words.pop_front();
         if (got.forward_speed !== want.forward_speed)
            report("forward_speed", got.forward_speed, want.forward_speed);
         if (got.yaw_rate !== want.yaw_rate)
            report("yaw_rate", got.yaw_rate, want.yaw_rate);
         if (got.wheel_rate !== want.wheel_rate)
            report("wheel_rate", got.wheel_rate, want.wheel_rate);
         if (got.err_angle !== want.err_angle)
            report("clamped error angle", got.err_angle, want.err_angle);
      endtask
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   logic                req_opcode = 0;
   logic signed [15:0]  req_vel_x = '0;
   logic signed [15:0]  req_vel_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic signed [15:0]  rsp_forward_speed;
   logic signed [15:0]  rsp_yaw_rate;
   logic signed [23:0]  rsp_wheel_rate;
   logic signed [15:0]  rsp_heading_error_out;
   logic                csr_write = 0;
   logic [1:0]          csr_index = '0;
   logic [15:0]         csr_wdata = '0;

   heading_scoreboard   sb = new();
   command_word_type    batch[$];
   int                  cycle_count = 0;
   int                  quiet_cycles = 0;
   int                  hold_left = 0;

   heading_error_velocity_command_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_forward_speed(rsp_forward_speed), .rsp_yaw_rate(rsp_yaw_rate),
      .rsp_wheel_rate(rsp_wheel_rate), .rsp_heading_error_out(rsp_heading_error_out),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic bit take_break();
      if (cycle_count >= 20000 && cycle_count < 30000) return 0;
      return $urandom_range(99) < 27;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_WAIT) begin
         $display("** heading_error_velocity_command_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count == 3000) begin
         hold_left <= 400;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= reset ? 1'b0 : take_break();
      end
   end

   always @(posedge clock) begin
      drive_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.forward_speed = rsp_forward_speed;
         got.yaw_rate = rsp_yaw_rate;
         got.wheel_rate = rsp_wheel_rate;
         got.err_angle = rsp_heading_error_out;
         sb.check_drive(got);
      end
   end

   function automatic logic signed [15:0] pick_velocity();
      logic signed [15:0] corners[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF};
      case ($urandom_range(3))
         0: return corners[$urandom_range(4)];
         1: return 16'($signed($urandom_range(1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_word(logic op, logic signed [15:0] x, logic signed [15:0] y);
      command_word_type w;
      w.opcode = op;
      w.vel_x = x;
      w.vel_y = y;
      batch.insert(batch.size(), w);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
      csr_write <= 0;
   endtask

   task automatic send_batch();
      int k;
      bit taken;
      k = 0;
      while (k < batch.size()) begin
         @(posedge clock);
         taken = req_valid && !req_stall;
         if (taken) begin
            sb.note_command(batch[k]);
            k++;
         end
         if (taken || !req_valid) begin
            if (k < batch.size() && !take_break()) begin
               req_valid <= 1;
               req_opcode <= batch[k].opcode;
               req_vel_x <= batch[k].vel_x;
               req_vel_y <= batch[k].vel_y;
            end else begin
               req_valid <= 0;
            end
         end
      end
      batch.delete();
   endtask

   task automatic drain();
      while (sb.pending_words.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      logic [15:0] g, l, r;
      repeat (10) @(posedge clock);
      reset <= 0;

      // A command against the zero measurement after reset, then the corner vectors.
      add_word(1, 16'sh0100, 16'sh0000);
      add_word(1, 16'sh0000, 16'sh0000);
      add_word(1, 16'sh7FFF, 16'sh7FFF);
      add_word(1, 16'sh8000, 16'sh8000);
      add_word(1, 16'sh8000, 16'sh0000);
      add_word(1, 16'sh0000, 16'sh8000);
      add_word(1, 16'sh7FFF, 16'sh8000);
      add_word(0, 16'sh0100, 16'sh0000);
      add_word(1, 16'sh8000, 16'sh0001);
      add_word(1, 16'sh8000, 16'shFFFF);
      add_word(1, 16'sh0000, 16'sh0000);
      add_word(0, 16'sh8000, 16'sh8000);
      add_word(1, 16'sh7FFF, 16'sh7FFF);
      add_word(1, 16'sh7FFF, 16'sh0000);
      add_word(0, 16'sh0000, 16'sh0000);
      add_word(1, 16'sh0000, 16'sh7FFF);
      send_batch();
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin g = 16'd0; l = 16'd0; r = 16'd1; end
            1: begin g = 16'hFFFF; l = 16'hFFFF; r = 16'hFFFF; end
            2: begin g = 16'd32767; l = 16'd32767; r = 16'd0; end
            3: begin g = 16'd5734; l = 16'd4096; r = 16'd1024; end
            default: begin g = 16'($urandom); l = 16'($urandom); r = 16'($urandom); end
         endcase
         write_csr(hevc_pkg::CSR_GAIN, g);
         write_csr(hevc_pkg::CSR_LIMIT, l);
         write_csr(hevc_pkg::CSR_IWR, r);
         write_csr(CSR_UNUSED, 16'($urandom));
         if (phase == 1) begin
            // Both full-scale opposite headings, so the error reaches the half turn.
            add_word(0, 16'sh8000, 16'sh0000);
            add_word(1, 16'sh7FFF, 16'sh0000);
            add_word(0, 16'sh0000, 16'sh7FFF);
            add_word(1, 16'sh0000, 16'sh8000);
         end
         for (int n = 0; n < 190; n++)
            add_word($urandom_range(1), pick_velocity(), pick_velocity());
         send_batch();
         drain();
      end

      if (sb.pending_words.size() == 0 && sb.errors == 0)
         $display("** heading_error_velocity_command_unit: PASSED **");
      else
         $display("** heading_error_velocity_command_unit: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
